FILE: rtl/vigmx_pkg.sv
// vigmx_pkg: types, codes and character constants shared by the
// mixed-alphabet Vigenere encipher block. No dependencies.
package vigmx_pkg;

  localparam int unsigned ALPHA         = 26;
  localparam int unsigned LINE_LETTERS  = 40;
  localparam int unsigned GROUP_LETTERS = 5;
  localparam int unsigned CFG_W         = 7;

  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_Z    = 8'h5A;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_SP   = 8'h20;

  typedef enum logic [2:0] {
    ACT_ENCIPHER    = 3'd0,
    ACT_LOAD_KEY    = 3'd1,
    ACT_LOAD_PLAIN  = 3'd2,
    ACT_LOAD_CIPHER = 3'd3,
    ACT_FINISH      = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    OP_LETTER = 3'd0,
    OP_KEY    = 3'd1,
    OP_PLAIN  = 3'd2,
    OP_CIPHER = 3'd3,
    OP_FINISH = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    SEP_NONE    = 2'd0,
    SEP_SPACE   = 2'd1,
    SEP_NEWLINE = 2'd2
  } sep_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [5:0] position;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // work item handed down the lookup pipeline
  typedef struct packed {
    op_e        op;
    logic [4:0] letter;
    logic [4:0] apos;
    sep_e       sep;
  } stage_t;

  // finished result pair before serialization
  typedef struct packed {
    logic [7:0] first;
    sep_e       sep;
  } res_t;

  function automatic logic [7:0] sep_byte(sep_e s);
    logic [7:0] b;
    b = (s == SEP_NEWLINE) ? CHAR_NL : CHAR_SP;
    return b;
  endfunction

endpackage

FILE: rtl/vigenere_mixed_alphabet_encipher_top.sv
// vigenere_mixed_alphabet_encipher_top: mixed-alphabet Vigenere encipherer.
// Instantiates vigmx_front, vigmx_lookup and vigmx_emit; uses vigmx_pkg.
//
//   channel | signals                        | moves
//   in      | in_valid_i/in_ready_o/in_data_i | action, data_byte, position
//   out     | out_valid_o/out_ready_i/out_data_o | out_byte, last
//   cfg     | cfg_valid_i/cfg_ready_o/cfg_data_i | key_length (7 bits)
//
// one input transfer per cycle while in_ready_o is high; a result passes the input
// register (loaded at the transfer edge), three table stages and the output register
// a letter with a separator or a finish leaves as two transfers; the output register
// takes its next result as the final one leaves and sets the sustained rate; stalls
// on the output back up stage by stage; empty stages fill except the second table
// stage while the last is held; reset clears counters and valid bits, sets key
// length to one; key and alphabet stores are unset until loaded; cfg is always ready
module vigenere_mixed_alphabet_encipher_top import vigmx_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned KIW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  logic           s1_valid, s1_ready;
  stage_t         s1_data;
  logic [KIW-1:0] s1_kaddr;
  logic           res_valid, res_ready;
  res_t           res_data;

  assign cfg_ready_o = 1'b1;

  vigmx_front #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .s1_valid_o  (s1_valid),
    .s1_ready_i  (s1_ready),
    .s1_data_o   (s1_data),
    .s1_kaddr_o  (s1_kaddr)
  );

  vigmx_lookup #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_ready_o  (s1_ready),
    .s1_data_i   (s1_data),
    .s1_kaddr_i  (s1_kaddr),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  vigmx_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_data_i  (res_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/vigmx_front.sv
// vigmx_front: input register, key length register, key position,
// line grouping and comment tracking. Depends on vigmx_pkg.
module vigmx_front import vigmx_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 64,
  localparam int unsigned KIW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1,
  localparam int unsigned LenW = ($clog2(KEY_DEPTH + 1) > CFG_W) ?
                                 $clog2(KEY_DEPTH + 1) : CFG_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  input  logic             cfg_valid_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             s1_valid_o,
  input  logic             s1_ready_i,
  output stage_t           s1_data_o,
  output logic [KIW-1:0]   s1_kaddr_o
);

  logic [CFG_W-1:0] key_length_q;
  logic [KIW-1:0]   key_pos_q, key_pos_d;
  logic [5:0]       line_q, line_d;
  logic [2:0]       group_q, group_d;
  logic             in_comment_q, in_comment_d;
  logic             s1_valid_q;
  stage_t           s1_q, item;
  logic [KIW-1:0]   s1_kaddr_q, kaddr;
  logic             item_vld, accept, letter_ok;
  logic [LenW-1:0]  len_cfg, eff_len, kp_inc;
  logic [KIW-1:0]   kp_use, kp_next;
  logic [5:0]       line_inc;
  logic [2:0]       group_inc;
  logic [4:0]       letter;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_o = s1_valid_q;
  assign s1_data_o  = s1_q;
  assign s1_kaddr_o = s1_kaddr_q;

  always_comb begin
    // zero acts as one, anything above the depth as the depth
    len_cfg = LenW'(key_length_q);
    if (len_cfg == '0) begin
      eff_len = LenW'(1);
    end else if (len_cfg > LenW'(KEY_DEPTH)) begin
      eff_len = LenW'(KEY_DEPTH);
    end else begin
      eff_len = len_cfg;
    end
    kp_use  = (LenW'(key_pos_q) >= eff_len) ? '0 : key_pos_q;
    kp_inc  = LenW'(kp_use) + LenW'(1);
    kp_next = (kp_inc >= eff_len) ? '0 : kp_inc[KIW-1:0];

    letter_ok = (in_data_i.data_byte >= CHAR_A) && (in_data_i.data_byte <= CHAR_Z);
    letter    = 5'(in_data_i.data_byte - CHAR_A);
    line_inc  = line_q + 6'd1;
    group_inc = group_q + 3'd1;

    key_pos_d    = key_pos_q;
    line_d       = line_q;
    group_d      = group_q;
    in_comment_d = in_comment_q;
    item_vld     = 1'b0;
    item         = '{op: OP_LETTER, letter: letter, apos: in_data_i.position[4:0],
                     sep: SEP_NONE};
    kaddr        = kp_use;

    unique case (act_e'(in_data_i.action))
      ACT_ENCIPHER: begin
        if (in_comment_q) begin
          if (in_data_i.data_byte == CHAR_NL) begin
            in_comment_d = 1'b0;
          end
        end else if (in_data_i.data_byte == CHAR_HASH) begin
          in_comment_d = 1'b1;
        end else if (letter_ok) begin
          item_vld  = 1'b1;
          key_pos_d = kp_next;
          if (line_inc >= 6'(LINE_LETTERS)) begin
            line_d   = '0;
            group_d  = '0;
            item.sep = SEP_NEWLINE;
          end else if (group_inc >= 3'(GROUP_LETTERS)) begin
            line_d   = line_inc;
            group_d  = '0;
            item.sep = SEP_SPACE;
          end else begin
            line_d  = line_inc;
            group_d = group_inc;
          end
        end
      end
      ACT_LOAD_KEY: begin
        if (letter_ok && (LenW'(in_data_i.position) < LenW'(KEY_DEPTH))) begin
          item_vld = 1'b1;
          item.op  = OP_KEY;
          kaddr    = KIW'(in_data_i.position);
        end
      end
      ACT_LOAD_PLAIN: begin
        if (letter_ok && (in_data_i.position < 6'(ALPHA))) begin
          item_vld = 1'b1;
          item.op  = OP_PLAIN;
        end
      end
      ACT_LOAD_CIPHER: begin
        if (letter_ok && (in_data_i.position < 6'(ALPHA))) begin
          item_vld = 1'b1;
          item.op  = OP_CIPHER;
        end
      end
      ACT_FINISH: begin
        key_pos_d    = '0;
        line_d       = '0;
        group_d      = '0;
        in_comment_d = 1'b0;
        item_vld     = 1'b1;
        item.op      = OP_FINISH;
        item.sep     = SEP_NEWLINE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= CFG_W'(1);
      key_pos_q    <= '0;
      line_q       <= '0;
      group_q      <= '0;
      in_comment_q <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        key_length_q <= cfg_data_i;
      end
      if (accept) begin
        key_pos_q    <= key_pos_d;
        line_q       <= line_d;
        group_q      <= group_d;
        in_comment_q <= in_comment_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= accept && item_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_vld) begin
      s1_q       <= item;
      s1_kaddr_q <= kaddr;
    end
  end

  a_finish_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.action == ACT_FINISH)
    |=> (key_pos_q == '0) && (line_q == '0) && (group_q == '0) && !in_comment_q)
    else $error("finish did not restart the counters");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q < 6'(LINE_LETTERS)) && (group_q < 3'(GROUP_LETTERS)))
    else $error("line or group counter out of range");

  a_comment_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_comment_q && (in_data_i.action == ACT_ENCIPHER) |=> !s1_valid_q)
    else $error("byte inside a comment produced work");

endmodule

FILE: rtl/vigmx_lookup.sv
// vigmx_lookup: three-stage table pipeline holding the key store and the inverse
// plain, inverse cipher and cipher alphabets. Depends on vigmx_pkg.
module vigmx_lookup import vigmx_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 64,
  localparam int unsigned KIW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s1_valid_i,
  output logic           s1_ready_o,
  input  stage_t         s1_data_i,
  input  logic [KIW-1:0] s1_kaddr_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output res_t           res_data_o
);

  // each table is written and read at the same stage, so loads and
  // letters see the tables in stream order
  logic [4:0] key_mem [KEY_DEPTH];
  logic [4:0] ip_mem  [ALPHA];
  logic [4:0] ic_mem  [ALPHA];
  logic [4:0] ca_mem  [ALPHA];

  logic       s2_valid_q, s3_valid_q, s4_valid_q;
  stage_t     s2_q, s3_q, s4_q;
  logic [4:0] s2_key_q, s2_ip_q, s3_ip_q, s3_ic_q, s4_ca_q;
  logic       s2_ready, s3_ready, s4_ready;
  logic       en1, en2, en3;
  logic [5:0] diff;
  logic [4:0] idx;

  assign s4_ready   = !s4_valid_q || res_ready_i;
  assign s3_ready   = s4_ready;
  assign s2_ready   = !s3_valid_q || s3_ready;
  assign s1_ready_o = !s2_valid_q || s2_ready;

  assign en1 = s1_valid_i && s1_ready_o;
  assign en2 = s2_valid_q && s2_ready;
  assign en3 = s3_valid_q && s3_ready;

  // (plain - key + 26) mod 26 with one conditional correction
  always_comb begin
    if (s3_ip_q >= s3_ic_q) begin
      diff = 6'(s3_ip_q) - 6'(s3_ic_q);
    end else begin
      diff = 6'(s3_ip_q) + 6'(ALPHA) - 6'(s3_ic_q);
    end
    idx = diff[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_ready_o) begin
        s2_valid_q <= s1_valid_i;
      end
      if (s2_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (s3_ready) begin
        // loads end here, only letters and finish carry results
        s4_valid_q <= s3_valid_q &&
                      ((s3_q.op == OP_LETTER) || (s3_q.op == OP_FINISH));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s2_q     <= s1_data_i;
      s2_key_q <= key_mem[s1_kaddr_i];
      s2_ip_q  <= ip_mem[s1_data_i.letter];
      if (s1_data_i.op == OP_KEY) begin
        key_mem[s1_kaddr_i] <= s1_data_i.letter;
      end
      if (s1_data_i.op == OP_PLAIN) begin
        ip_mem[s1_data_i.letter] <= s1_data_i.apos;
      end
    end
    if (en2) begin
      s3_q    <= s2_q;
      s3_ip_q <= s2_ip_q;
      s3_ic_q <= ic_mem[s2_key_q];
      if (s2_q.op == OP_CIPHER) begin
        ic_mem[s2_q.letter] <= s2_q.apos;
      end
    end
    if (en3) begin
      s4_q    <= s3_q;
      s4_ca_q <= ca_mem[idx];
      if (s3_q.op == OP_CIPHER) begin
        ca_mem[s3_q.apos] <= s3_q.letter;
      end
    end
  end

  assign res_valid_o      = s4_valid_q;
  assign res_data_o.first = (s4_q.op == OP_FINISH) ? CHAR_NL : (CHAR_A + {3'b000, s4_ca_q});
  assign res_data_o.sep   = s4_q.sep;

endmodule

FILE: rtl/vigmx_emit.sv
// vigmx_emit: output register that sends a letter and its optional
// separator as one or two transfers. Depends on vigmx_pkg.
module vigmx_emit import vigmx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  output logic      res_ready_o,
  input  res_t      res_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic       e_valid_q;
  logic       phase_q;
  logic [7:0] e_byte_q;
  sep_e       e_sep_q;
  logic       final_beat, take;

  // second beat is the separator
  assign final_beat  = phase_q || (e_sep_q == SEP_NONE);
  assign take        = !e_valid_q || (out_ready_i && final_beat);
  assign res_ready_o = take;

  assign out_valid_o         = e_valid_q;
  assign out_data_o.out_byte = phase_q ? sep_byte(e_sep_q) : e_byte_q;
  assign out_data_o.last     = final_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      phase_q   <= 1'b0;
    end else begin
      if (take) begin
        e_valid_q <= res_valid_i;
        phase_q   <= 1'b0;
      end else if (out_ready_i) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid_i) begin
      e_byte_q <= res_data_i.first;
      e_sep_q  <= res_data_i.sep;
    end
  end

  a_phase_has_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> e_valid_q && (e_sep_q != SEP_NONE))
    else $error("separator beat without a separator");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o && out_data_o.last)
    else $error("first beat of a pair not followed by its final beat");

  a_sep_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_q |->
      (out_data_o.out_byte == CHAR_SP) || (out_data_o.out_byte == CHAR_NL))
    else $error("separator beat carries a non-separator byte");

endmodule
